>>> hdl/mse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

    localparam int IDX_W    = 14;
    localparam int Q_DEPTH  = 3;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 2;

    localparam logic [31:0] SEGMENT_RESET = 32'h1000_0000;
    localparam logic [31:0] REGION_MASK   = 32'hF000_0000;
    localparam logic [IDX_W-1:0] PC_READ_INDEX = IDX_W'(32);

    localparam logic REG_DATA_SEGMENT_BASE = 1'b0;

    localparam logic [5:0] OPC_SPECIAL = 6'b000000;
    localparam logic [5:0] OPC_ADDI    = 6'b001000;
    localparam logic [5:0] OPC_ANDI    = 6'b001100;
    localparam logic [5:0] OPC_BEQ     = 6'b000100;
    localparam logic [5:0] OPC_BNE     = 6'b000101;
    localparam logic [5:0] OPC_LW      = 6'b100011;
    localparam logic [5:0] OPC_ORI     = 6'b001101;
    localparam logic [5:0] OPC_SLTI    = 6'b001010;
    localparam logic [5:0] OPC_LUI     = 6'b001111;
    localparam logic [5:0] OPC_SW      = 6'b101011;
    localparam logic [5:0] OPC_J       = 6'b000010;

    localparam logic [5:0] FN_NOP = 6'h00;
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_SLT = 6'h2A;

    typedef enum logic [1:0] {
        OPER_EXEC   = 2'd0,
        OPER_RD_REG = 2'd1,
        OPER_RD_MEM = 2'd2
    } t_operation;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] read_data;
        logic        unknown;
        logic        halted;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/mse_rf.sv
`timescale 1ns / 1ps
`default_nettype none

module mse_rf import mse_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [4:0]  i_ra,
    input  wire logic [4:0]  i_rb,
    input  wire t_rf_wr      i_wr,
    output logic      [31:0] o_a,
    output logic      [31:0] o_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_da;
    logic [31:0] r_db;
    logic        r_va;
    logic        r_vb;
    logic        r_fwd_a;
    logic        r_fwd_b;
    logic [31:0] r_fwd_d;
    logic        wr_ok;

    assign wr_ok = i_wr.we && (i_wr.addr != 5'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_ok) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_da    <= r_mem[i_ra];
        r_db    <= r_mem[i_rb];
        r_va    <= r_valid[i_ra];
        r_vb    <= r_valid[i_rb];
        // write in the same cycle as the read: pass the new value
        r_fwd_a <= wr_ok && (i_wr.addr == i_ra);
        r_fwd_b <= wr_ok && (i_wr.addr == i_rb);
        r_fwd_d <= i_wr.data;
    end

    assign o_a = r_fwd_a ? r_fwd_d : (r_va ? r_da : 32'd0);
    assign o_b = r_fwd_b ? r_fwd_d : (r_vb ? r_db : 32'd0);

endmodule

`default_nettype wire

>>> hdl/mse_dmem.sv
`timescale 1ns / 1ps
`default_nettype none

module mse_dmem #(
    parameter  int DATA_WORDS = 16384,
    localparam int ADDR_W     = $clog2(DATA_WORDS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_wa,
    input  wire logic [31:0]       i_wd,
    input  wire logic [ADDR_W-1:0] i_ra,
    output logic      [31:0]       o_rd,
    output logic                   o_busy
);

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DATA_WORDS - 1);

    logic [31:0]       r_mem [DATA_WORDS];
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [31:0]       r_rd;
    logic              r_fwd;
    logic [31:0]       r_fwd_d;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [31:0]       wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign we = r_busy || i_we;
    assign wa = r_busy ? r_clr_addr : i_wa;
    assign wd = r_busy ? 32'hFFFF_FFFF : i_wd;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd    <= r_mem[i_ra];
        r_fwd   <= i_we && !r_busy && (i_wa == i_ra);
        r_fwd_d <= i_wd;
    end

    assign o_rd   = r_fwd ? r_fwd_d : r_rd;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

>>> hdl/mse_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module mse_outq import mse_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire t_result            i_data,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output t_result                 o_data,
    output logic      [Q_CNT_W-1:0] o_count
);

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);

    t_result            r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               pop;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> hdl/mips_subset_execute_unit.sv
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata: instruction, read_index; tuser: operation
// m_axis    out  tvalid/tready           tdata: next_pc, read_data; tuser: unknown, halted
// apb       in   psel/penable/pready     data_segment_base at byte address 0
//
// Items issue one per cycle while s_axis_tready is high; a taken lw holds the input while the
// data memory read completes and writes back the register file.
// Results are pushed from stage 1 (stage 2 for lw) into a 3-entry output queue.
// After reset the data memory is swept to all ones, with the input not ready.
// A stalled output stops the input only once the queue has no room left.
// DATA_WORDS must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module mips_subset_execute_unit import mse_pkg::*; #(
    parameter int DATA_WORDS = 16384
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [31:0] instruction, [45:32] read_index
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,   // [31:0] next_pc, [63:32] read_data
    output logic      [1:0]  m_axis_tuser,   // [0] unknown_instruction, [1] halted

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int ADDR_W = $clog2(DATA_WORDS);

    logic              accept;
    logic [31:0]       in_inst;
    logic [IDX_W-1:0]  in_idx;
    logic [31:0]       in_idx_ext;
    logic [4:0]        rf_ra;

    logic              r_s1_valid;
    t_operation        r_s1_op;
    logic [31:0]       r_s1_inst;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s2_valid;
    logic [4:0]        r_s2_rt;
    logic [31:0]       r_pc;
    logic              r_stopped;
    logic [31:0]       r_base;
    logic [31:0]       n_pc;
    logic              n_stopped;

    logic [31:0]       rf_a;
    logic [31:0]       rf_b;
    t_rf_wr            s1_rf_wr;
    t_rf_wr            rf_wr;

    logic              dm_busy;
    logic              dm_we;
    logic [ADDR_W-1:0] dm_ra;
    logic [31:0]       dm_rd;
    logic [31:0]       mem_addr;
    logic [ADDR_W-1:0] mem_index;

    logic [5:0]        opc;
    logic [5:0]        fn;
    logic [4:0]        rs_f;
    logic [4:0]        rt_f;
    logic [4:0]        rd_f;
    logic [31:0]       uimm;
    logic [31:0]       simm;
    logic [31:0]       pc4;
    logic              known;
    logic              exec_live;
    logic              s1_is_lw;

    t_result           s1_res;
    t_result           q_in;
    t_result           q_out;
    logic              q_push;
    logic [Q_CNT_W-1:0] q_count;
    logic [Q_CNT_W:0]  q_claim;

    // input side
    assign in_inst    = s_axis_tdata[31:0];
    assign in_idx     = s_axis_tdata[32 +: IDX_W];
    assign in_idx_ext = {{(32 - IDX_W){1'b0}}, in_idx};
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign rf_ra      = (s_axis_tuser == OPER_RD_REG) ? in_idx[4:0] : in_inst[25:21];

    assign q_claim       = {1'b0, q_count} + {{Q_CNT_W{1'b0}}, (r_s1_valid || r_s2_valid)};
    assign s_axis_tready = !dm_busy && !s1_is_lw && (q_claim < (Q_CNT_W + 1)'(Q_DEPTH));

    // instruction fields
    assign opc  = r_s1_inst[31:26];
    assign rs_f = r_s1_inst[25:21];
    assign rt_f = r_s1_inst[20:16];
    assign rd_f = r_s1_inst[15:11];
    assign fn   = r_s1_inst[5:0];
    assign uimm = {16'd0, r_s1_inst[15:0]};
    assign simm = {{16{r_s1_inst[15]}}, r_s1_inst[15:0]};
    assign pc4  = r_pc + 32'd4;

    assign mem_addr  = (rf_a ^ r_base) + simm;
    assign mem_index = mem_addr[ADDR_W+1:2];
    assign exec_live = r_s1_valid && (r_s1_op == OPER_EXEC) && !r_stopped;
    assign s1_is_lw  = exec_live && (opc == OPC_LW);
    assign dm_we     = exec_live && (opc == OPC_SW);
    assign dm_ra     = s1_is_lw ? mem_index : in_idx_ext[ADDR_W-1:0];

    always_comb begin
        n_pc     = r_pc;
        known    = 1'b1;
        s1_rf_wr = '0;
        if (exec_live) begin
            n_pc = pc4;
            case (opc)
                OPC_SPECIAL: begin
                    s1_rf_wr.addr = rd_f;
                    s1_rf_wr.we   = 1'b1;
                    case (fn)
                        FN_ADD:  s1_rf_wr.data = rf_a + rf_b;
                        FN_SUB:  s1_rf_wr.data = rf_a - rf_b;
                        FN_AND:  s1_rf_wr.data = rf_a & rf_b;
                        FN_OR:   s1_rf_wr.data = rf_a | rf_b;
                        FN_SLT:  s1_rf_wr.data = {31'd0, $signed(rf_a) < $signed(rf_b)};
                        FN_NOP:  s1_rf_wr.we   = 1'b0;
                        default: begin
                            s1_rf_wr.we = 1'b0;
                            known       = 1'b0;
                        end
                    endcase
                end
                OPC_ADDI: s1_rf_wr = '{we: 1'b1, addr: rt_f, data: rf_a + simm};
                OPC_ANDI: s1_rf_wr = '{we: 1'b1, addr: rt_f, data: rf_a & uimm};
                OPC_ORI:  s1_rf_wr = '{we: 1'b1, addr: rt_f, data: rf_a | uimm};
                OPC_SLTI: s1_rf_wr = '{we: 1'b1, addr: rt_f,
                                       data: {31'd0, $signed(rf_a) < $signed(simm)}};
                OPC_LUI:  s1_rf_wr = '{we: 1'b1, addr: rt_f, data: {uimm[15:0], 16'd0}};
                OPC_BEQ: begin
                    if (rf_a == rf_b) begin
                        n_pc = pc4 + {simm[29:0], 2'b00};
                    end
                end
                OPC_BNE: begin
                    if (rf_a != rf_b) begin
                        n_pc = pc4 + {simm[29:0], 2'b00};
                    end
                end
                OPC_J:   n_pc = (pc4 & REGION_MASK) | ({r_s1_inst[29:0], 2'b00} & ~REGION_MASK);
                OPC_LW:  known = 1'b1;
                OPC_SW:  known = 1'b1;
                default: known = 1'b0;
            endcase
        end
    end

    assign n_stopped = r_stopped || (exec_live && !known);

    always_comb begin
        s1_res           = '0;
        s1_res.next_pc   = n_pc;
        s1_res.halted    = n_stopped;
        s1_res.unknown   = exec_live && !known;
        case (r_s1_op)
            OPER_RD_REG: begin
                if (r_s1_idx < PC_READ_INDEX) begin
                    s1_res.read_data = rf_a;
                end else if (r_s1_idx == PC_READ_INDEX) begin
                    s1_res.read_data = r_pc;
                end
            end
            OPER_RD_MEM: s1_res.read_data = dm_rd;
            default:     s1_res.read_data = 32'd0;
        endcase
    end

    // lw writeback and result shares the queue port with stage 1; never both at once
    always_comb begin
        if (r_s2_valid) begin
            rf_wr  = '{we: 1'b1, addr: r_s2_rt, data: dm_rd};
            q_in   = '{next_pc: r_pc, read_data: 32'd0, unknown: 1'b0, halted: r_stopped};
            q_push = 1'b1;
        end else begin
            rf_wr  = s1_rf_wr;
            q_in   = s1_res;
            q_push = r_s1_valid && !s1_is_lw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_pc       <= '0;
            r_stopped  <= 1'b0;
            r_base     <= SEGMENT_RESET;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= s1_is_lw;
            if (r_s1_valid) begin
                r_pc      <= n_pc;
                r_stopped <= n_stopped;
            end
            if (psel && penable && pwrite && pready && (paddr[2] == REG_DATA_SEGMENT_BASE)) begin
                r_base <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= t_operation'(s_axis_tuser);
            r_s1_inst <= in_inst;
            r_s1_idx  <= in_idx;
        end
        if (s1_is_lw) begin
            r_s2_rt <= rt_f;
        end
    end

    mse_rf u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ra    (rf_ra),
        .i_rb    (in_inst[20:16]),
        .i_wr    (rf_wr),
        .o_a     (rf_a),
        .o_b     (rf_b)
    );

    mse_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (dm_we),
        .i_wa    (mem_index),
        .i_wd    (rf_b),
        .i_ra    (dm_ra),
        .o_rd    (dm_rd),
        .o_busy  (dm_busy)
    );

    mse_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign m_axis_tdata = {q_out.read_data, q_out.next_pc};
    assign m_axis_tuser = {q_out.halted, q_out.unknown};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DATA_SEGMENT_BASE) ? r_base : 32'd0;

endmodule

`default_nettype wire

>>> hdl/mse_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    logic r_seen_halt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[1]) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen_halt |-> m_axis_tuser[1])
        else $error("halt dropped after it was reported");

    a_unknown_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("unknown instruction without halt");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("activity right after reset");

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
